// ===== src/aiff_stream_decoder_top_macros.svh =====
// Assertion macros shared by the AIFF stream decoder modules.
// Depends on nothing; the SYNTH build gets empty bodies.
`ifndef AIFF_STREAM_DECODER_TOP_MACROS_SVH
`define AIFF_STREAM_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASD_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASD_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg)
`define ASD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/asd_pkg.sv =====
// Shared types, tags, status codes and the extended-to-integer rate function
// for the AIFF stream decoder. No dependencies.
`timescale 1ns / 1ps
package asd_pkg;

	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_AIFC = 32'h41494643;
	localparam logic [31:0] TAG_AIFF = 32'h41494646;
	localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
	localparam logic [31:0] TAG_SSND = 32'h53534E44;
	localparam logic [31:0] TAG_NONE = 32'h4E4F4E45;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOT_AIFF     = 3'd1;
	localparam logic [2:0] ST_MALFORMED    = 3'd2;
	localparam logic [2:0] ST_UNSUPPORTED  = 3'd3;
	localparam logic [2:0] ST_MISSING_COMM = 3'd4;

	localparam logic [14:0] EXP_BIAS       = 15'd16383;
	localparam logic [14:0] EXP_ZERO_SHIFT = EXP_BIAS + 15'd63;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic        kind;
		logic [31:0] sample;
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [5:0]  bits;
		logic        last;
	} result_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_t;

	function automatic logic [31:0] ext_to_rate(input logic [15:0] se,
		input logic [63:0] mant);
		logic [14:0] expo;
		logic [14:0] up;
		logic [14:0] dn;
		logic [63:0] sh;
		logic [5:0]  rbit;
		logic [31:0] r;
		expo = se[14:0];
		up   = expo - EXP_ZERO_SHIFT;
		dn   = EXP_ZERO_SHIFT - expo;
		sh   = mant >> dn[5:0];
		rbit = dn[5:0] - 6'd1;
		r    = '0;
		if (se[15] || expo == '0 || mant == '0) begin
			r = '0;
		end else if (expo > EXP_ZERO_SHIFT) begin
			r = (up >= 15'd32) ? 32'd0 : (mant[31:0] << up[4:0]);
		end else if (expo == EXP_ZERO_SHIFT) begin
			r = mant[31:0];
		end else if (dn >= 15'd64) begin
			r = '0;
		end else begin
			r = sh[31:0] + {31'd0, mant[rbit]};
		end
		return r;
	endfunction

endpackage

// ===== src/asd_parser.sv =====
// Per-byte parse logic of the AIFF stream decoder: file state registers and
// the next-state / result logic. Depends on asd_pkg.
`timescale 1ns / 1ps
module asd_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        byte_s1,
	input  logic [31:0]       file_length_q,
	output asd_pkg::push_t    push,
	output asd_pkg::result_t  res_a,
	output asd_pkg::result_t  res_b
);

	localparam int PW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 3;

	typedef enum logic [3:0] {
		PH_HEADER, PH_CHUNK_HDR, PH_COMM, PH_SKIP, PH_PAD,
		PH_SSND_HDR, PH_SSND_OFS, PH_SAMPLES, PH_DONE
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [PW-1:0] pos_q, cstart_q, n_pos, n_cstart;
	logic [31:0] tag_q, clen_q, frames_q, rate_q, ofs_q, asm_q;
	logic [31:0] n_tag, n_clen, n_frames, n_rate, n_ofs, n_asm;
	logic [15:0] chan_q, bits_q, se_q, n_chan, n_bits, n_se;
	logic [63:0] mant_q, n_mant;
	logic [47:0] left_q, n_left, prod_q;
	logic [1:0]  bis_q, n_bis;
	logic        aifc_q, comm_q, n_aifc, n_comm;

	logic [PW-1:0] len_m, len, off, boff, check_at, ce_next, hz_next, hdr_end;
	logic [50:0] need;
	logic [31:0] avail, sv;
	logic [12:0] bpb;
	logic        fin, smp;
	logic [2:0]  fin_st;

	assign len_m = PW'(file_length_q) & PW'({LENGTH_BITS{1'b1}});
	assign len   = (len_m == '0) ? PW'(1) : len_m;
	assign off   = pos_q - cstart_q;
	assign boff  = off - PW'(8);
	assign ce_next = cstart_q + PW'(8) + PW'(clen_q) + PW'(clen_q[0]);
	assign hz_next = cstart_q + PW'(8);
	assign bpb   = bits_q[15:3];
	assign avail = clen_q - 32'd8 - ofs_q;

	always_comb begin
		case (bits_q[5:3])
			3'd2:    need = {2'b0, prod_q, 1'b0};
			3'd3:    need = 51'(prod_q) + {2'b0, prod_q, 1'b0};
			3'd4:    need = {1'b0, prod_q, 2'b0};
			default: need = 51'(prod_q);
		endcase
	end

	always_comb begin
		n_phase = phase_q; n_pos = pos_q + PW'(1); n_cstart = cstart_q;
		n_tag = tag_q; n_clen = clen_q; n_frames = frames_q; n_rate = rate_q;
		n_ofs = ofs_q; n_asm = asm_q; n_chan = chan_q; n_bits = bits_q;
		n_se = se_q; n_mant = mant_q; n_left = left_q; n_bis = bis_q;
		n_aifc = aifc_q; n_comm = comm_q;
		fin = 1'b0; fin_st = asd_pkg::ST_OK; smp = 1'b0; sv = '0;
		hdr_end  = hz_next + PW'(n_clen);
		check_at = (aifc_q && clen_q >= 32'd22) ? PW'(21) : PW'(17);
		unique case (phase_q)
			PH_HEADER: begin
				n_tag = {tag_q[23:0], byte_s1};
				if (pos_q == '0 && len < PW'(12)) begin
					fin = 1'b1; fin_st = asd_pkg::ST_NOT_AIFF;
				end else if (pos_q == PW'(3) && n_tag != asd_pkg::TAG_FORM) begin
					fin = 1'b1; fin_st = asd_pkg::ST_NOT_AIFF;
				end else if (pos_q >= PW'(11)) begin
					if (n_tag != asd_pkg::TAG_AIFC && n_tag != asd_pkg::TAG_AIFF) begin
						fin = 1'b1; fin_st = asd_pkg::ST_NOT_AIFF;
					end else begin
						n_aifc = aifc_q | (n_tag == asd_pkg::TAG_AIFC);
						n_cstart = PW'(12);
						if (len < PW'(20)) begin
							fin = 1'b1; fin_st = asd_pkg::ST_MISSING_COMM;
						end else begin
							n_phase = PH_CHUNK_HDR;
						end
					end
				end
			end
			PH_CHUNK_HDR: begin
				if (off < PW'(4)) n_tag = {tag_q[23:0], byte_s1};
				else n_clen = {clen_q[23:0], byte_s1};
				hdr_end = hz_next + PW'(n_clen);
				if (off >= PW'(7)) begin
					if (hdr_end > len) begin
						fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
					end else if (n_tag == asd_pkg::TAG_COMM) begin
						if (n_clen < 32'd18) begin
							fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
						end else begin
							n_phase = PH_COMM;
						end
					end else if (n_tag == asd_pkg::TAG_SSND) begin
						if (!comm_q) begin
							fin = 1'b1; fin_st = asd_pkg::ST_MISSING_COMM;
						end else if (n_clen < 32'd8) begin
							fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
						end else begin
							n_phase = PH_SSND_HDR;
						end
					end else if (n_clen == '0) begin
						if (hz_next + PW'(8) > len) begin
							fin = 1'b1;
							fin_st = comm_q ? asd_pkg::ST_MALFORMED : asd_pkg::ST_MISSING_COMM;
						end else begin
							n_cstart = hz_next; n_phase = PH_CHUNK_HDR;
						end
					end else begin
						n_phase = PH_SKIP;
					end
				end
			end
			PH_COMM: begin
				if (boff < PW'(2)) n_chan = {chan_q[7:0], byte_s1};
				else if (boff < PW'(6)) n_frames = {frames_q[23:0], byte_s1};
				else if (boff < PW'(8)) n_bits = {bits_q[7:0], byte_s1};
				else if (boff < PW'(10)) n_se = {se_q[7:0], byte_s1};
				else if (boff < PW'(18)) n_mant = {mant_q[55:0], byte_s1};
				else if (boff < PW'(22)) n_tag = {tag_q[23:0], byte_s1};
				if (boff == PW'(17)) n_rate = asd_pkg::ext_to_rate(n_se, n_mant);
				if (boff == check_at && check_at == PW'(21)
					&& n_tag != asd_pkg::TAG_NONE) begin
					fin = 1'b1; fin_st = asd_pkg::ST_UNSUPPORTED;
				end else if (boff == check_at && (n_chan == '0 || n_rate == '0)) begin
					fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
				end else if (boff == check_at && n_bits != 16'd8 && n_bits != 16'd16
					&& n_bits != 16'd24 && n_bits != 16'd32) begin
					fin = 1'b1; fin_st = asd_pkg::ST_UNSUPPORTED;
				end else begin
					if (boff == check_at) n_comm = 1'b1;
					if (boff + PW'(1) >= PW'(clen_q)) begin
						if (ce_next + PW'(8) > len) begin
							fin = 1'b1;
							fin_st = n_comm ? asd_pkg::ST_MALFORMED : asd_pkg::ST_MISSING_COMM;
						end else begin
							n_cstart = ce_next;
							n_phase = clen_q[0] ? PH_PAD : PH_CHUNK_HDR;
						end
					end
				end
			end
			PH_SKIP: begin
				if (boff + PW'(1) >= PW'(clen_q)) begin
					if (ce_next + PW'(8) > len) begin
						fin = 1'b1;
						fin_st = comm_q ? asd_pkg::ST_MALFORMED : asd_pkg::ST_MISSING_COMM;
					end else begin
						n_cstart = ce_next;
						n_phase = clen_q[0] ? PH_PAD : PH_CHUNK_HDR;
					end
				end
			end
			PH_PAD: n_phase = PH_CHUNK_HDR;
			PH_SSND_HDR: begin
				if (boff < PW'(4)) n_ofs = {ofs_q[23:0], byte_s1};
				if (boff >= PW'(7)) begin
					if (ofs_q > clen_q - 32'd8) begin
						fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
					end else if (need > 51'(avail)) begin
						fin = 1'b1; fin_st = asd_pkg::ST_MALFORMED;
					end else begin
						n_left = prod_q; n_bis = '0; n_asm = '0;
						if (prod_q == '0) begin
							fin = 1'b1; fin_st = asd_pkg::ST_OK;
						end else begin
							n_phase = (ofs_q != '0) ? PH_SSND_OFS : PH_SAMPLES;
						end
					end
				end
			end
			PH_SSND_OFS: begin
				if (boff + PW'(1) >= PW'(8) + PW'(ofs_q)) n_phase = PH_SAMPLES;
			end
			PH_SAMPLES: begin
				n_asm = {asm_q[23:0], byte_s1};
				if (bpb == '0 || {11'd0, bis_q} + 13'd1 >= bpb) begin
					case (bits_q)
						16'd8:   sv = {{24{n_asm[7]}}, n_asm[7:0]};
						16'd16:  sv = {{16{n_asm[15]}}, n_asm[15:0]};
						16'd24:  sv = {{8{n_asm[23]}}, n_asm[23:0]};
						default: sv = n_asm;
					endcase
					smp = 1'b1; n_asm = '0; n_bis = '0;
					if (left_q != '0) n_left = left_q - 48'd1;
					if (n_left == '0) begin
						fin = 1'b1; fin_st = asd_pkg::ST_OK;
					end
				end else begin
					n_bis = bis_q + 2'd1;
				end
			end
			PH_DONE: n_phase = PH_DONE;
			default: n_phase = phase_q;
		endcase
		if (fin) n_phase = PH_DONE;
	end

	always_comb begin
		res_b.kind     = 1'b1;
		res_b.sample   = '0;
		res_b.status   = fin_st;
		res_b.channels = n_chan;
		res_b.rate     = n_rate;
		res_b.bits     = n_bits[5:0];
		res_b.last     = 1'b1;
		res_a          = res_b;
		if (smp) begin
			res_a.kind   = 1'b0;
			res_a.sample = sv;
			res_a.status = asd_pkg::ST_OK;
			res_a.last   = 1'b0;
		end
		push.push_a = adv && (smp || fin);
		push.push_b = adv && smp && fin;
	end

	// frames times channels, ready long before the sound header ends
	always_ff @(posedge clk) begin
		prod_q <= 48'(frames_q) * 48'(chan_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; pos_q <= '0; cstart_q <= PW'(12);
			tag_q <= '0; clen_q <= '0; aifc_q <= 1'b0; comm_q <= 1'b0;
			chan_q <= '0; frames_q <= '0; bits_q <= '0; se_q <= '0; mant_q <= '0;
			rate_q <= '0; ofs_q <= '0; left_q <= '0; asm_q <= '0; bis_q <= '0;
		end else if (adv) begin
			if (n_pos >= len) begin
				phase_q <= PH_HEADER; pos_q <= '0; cstart_q <= PW'(12);
				tag_q <= '0; clen_q <= '0; aifc_q <= 1'b0; comm_q <= 1'b0;
				chan_q <= '0; frames_q <= '0; bits_q <= '0; se_q <= '0; mant_q <= '0;
				rate_q <= '0; ofs_q <= '0; left_q <= '0; asm_q <= '0; bis_q <= '0;
			end else begin
				phase_q <= n_phase; pos_q <= n_pos; cstart_q <= n_cstart;
				tag_q <= n_tag; clen_q <= n_clen; aifc_q <= n_aifc; comm_q <= n_comm;
				chan_q <= n_chan; frames_q <= n_frames; bits_q <= n_bits;
				se_q <= n_se; mant_q <= n_mant; rate_q <= n_rate; ofs_q <= n_ofs;
				left_q <= n_left; asm_q <= n_asm; bis_q <= n_bis;
			end
		end
	end

endmodule

// ===== src/asd_out_fifo.sv =====
// Result queue of the AIFF stream decoder: takes up to two results a cycle,
// hands out one. Depends on asd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "aiff_stream_decoder_top_macros.svh"
module asd_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  asd_pkg::push_t   push,
	input  asd_pkg::result_t res_a,
	input  asd_pkg::result_t res_b,
	input  logic             out_stall,
	output logic             out_valid,
	output asd_pkg::result_t head,
	output logic             room
);

	asd_pkg::result_t mem_q [asd_pkg::QDEPTH];
	logic [asd_pkg::QPTR_W-1:0] head_q, tail_q, tail_b;
	logic [asd_pkg::QCNT_W-1:0] count_q, n_push;
	logic pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign head      = mem_q[head_q];
	assign room      = (count_q <= asd_pkg::QCNT_W'(asd_pkg::QDEPTH - 2));
	assign tail_b    = tail_q + asd_pkg::QPTR_W'(1);
	assign n_push    = asd_pkg::QCNT_W'(push.push_a) + asd_pkg::QCNT_W'(push.push_b);

	always_ff @(posedge clk) begin
		if (push.push_a) mem_q[tail_q] <= res_a;
		if (push.push_b) mem_q[tail_b] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + asd_pkg::QPTR_W'(1);
			tail_q  <= tail_q + asd_pkg::QPTR_W'(n_push);
			count_q <= count_q + n_push - asd_pkg::QCNT_W'(pop);
		end
	end

	`ASD_ASSERT_IMPL(a_cnt_max, clk, arst_n, 1'b1, count_q <= asd_pkg::QCNT_W'(asd_pkg::QDEPTH), "result queue count above depth")
	`ASD_ASSERT_IMPL(a_push_room, clk, arst_n, push.push_a, room, "push without room for two results")
	`ASD_ASSERT_IMPL(a_pair_order, clk, arst_n, push.push_b, res_b.last && !res_a.last, "status must follow the sample in a pair")
	`ASD_ASSERT_NEXT(a_pop_only, clk, arst_n, pop && !push.push_a, count_q == $past(count_q) - asd_pkg::QCNT_W'(1), "pop did not lower count")

endmodule

// ===== src/aiff_stream_decoder_top.sv =====
// AIFF/AIFC stream decoder, byte in, sample or status result out: one input
// register, the per-byte parser and a four-entry result queue. A taken byte
// is held in the input register; its results enter the queue when it moves
// on, and the queue head drives the outputs. Rate: one byte per cycle while
// the queue holds two or fewer results (a byte may produce a sample and the
// status at once). Reset (arst_n low, asynchronous) empties the queue, sets
// file_length to 1 and starts a new file.
`timescale 1ns / 1ps
module aiff_stream_decoder_top #(
	parameter int LENGTH_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               file_length_we,
	input  logic [31:0]        file_length,
	// byte requests
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	// result requests
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic signed [31:0] sample_value,
	output logic [2:0]         status_code,
	output logic [15:0]        channel_count,
	output logic [31:0]        rate_hz,
	output logic [5:0]         sample_bits,
	output logic               last_of_file
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [31:0]      file_length_q;
	logic             room, adv;
	asd_pkg::push_t   push;
	asd_pkg::result_t res_a, res_b, head;

	// Advance the held byte whenever the queue can take two results; hold it
	// otherwise and stall the sender.
	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= 32'd1;
		end else if (file_length_we) begin
			file_length_q <= file_length;
		end
	end

	// Input register: refill when empty or when its byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || adv) && in_valid) byte_s1 <= data_byte;
	end

	asd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.byte_s1       (byte_s1),
		.file_length_q (file_length_q),
		.push          (push),
		.res_a         (res_a),
		.res_b         (res_b)
	);

	asd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_a     (res_a),
		.res_b     (res_b),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	// Drive the result fields straight from the queue head.
	assign result_kind   = head.kind;
	assign sample_value  = head.sample;
	assign status_code   = head.status;
	assign channel_count = head.channels;
	assign rate_hz       = head.rate;
	assign sample_bits   = head.bits;
	assign last_of_file  = head.last;

endmodule

// ===== verif/aiff_stream_decoder_top_test.sv =====
// Self-checking testbench for aiff_stream_decoder_top: builds AIFF/AIFC files byte by byte,
// predicts every sample and status result in a scoreboard class and checks the output stream.
// Depends on asd_pkg (tags, status codes, result_t) and the decoder RTL.
`timescale 1ns / 1ps
module aiff_stream_decoder_top_test;

	typedef enum logic [3:0] {
		P_HEADER, P_CHUNK_HDR, P_COMM, P_SKIP, P_PAD, P_SSND_HDR, P_SSND_OFS, P_SAMPLES, P_DONE
	} parse_phase_t;

	// Tag of a chunk that the decoder must skip.
	localparam logic [31:0] TAG_JUNK = 32'h4A554E4B;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_BYTES = 1850;

	// Generator modes: each shapes one file toward a given path through the parser.
	localparam int M_AIFF = 0, M_AIFC = 1, M_AIFC_COMPRESSED = 2, M_NO_FORM = 3;
	localparam int M_BAD_FORM_TYPE = 4, M_SSND_FIRST = 5, M_SHORT_COMM = 6, M_NO_CHANNELS = 7;
	localparam int M_BAD_BITS = 8, M_FLAT_RATE = 9, M_NO_FRAMES = 10, M_BAD_OFFSET = 11;
	localparam int M_GARBAGE = 12, M_JUNK_CHUNK = 13, M_COUNT = 14;

	class sample_scoreboard_t;
		asd_pkg::result_t expected[$];
		int errors;
		longint unsigned flen;
		longint unsigned pos, cstart;
		parse_phase_t phase;
		bit [31:0] ctag, clen, frames, rate, doff, asm_word;
		bit [15:0] ch, bits, se;
		bit [63:0] mant;
		bit [47:0] left;
		bit [1:0] bis;
		bit aifc, comm;

		function new();
			errors = 0;
			flen = 1;
			clear_file();
		endfunction

		function void clear_file();
			pos = 0; phase = P_HEADER; cstart = 12; ctag = 0; clen = 0; aifc = 0; comm = 0;
			ch = 0; frames = 0; bits = 0; se = 0; mant = 0; rate = 0; doff = 0; left = 0;
			asm_word = 0; bis = 0;
		endfunction

		function bit [31:0] rate_from_extended();
			int shift;
			int down;
			bit [14:0] expo;
			bit [63:0] v, rem, half;
			expo = se[14:0];
			if (se[15] || expo == 0 || mant == 0) return 32'd0;
			shift = int'(expo) - 16383 - 63;
			if (shift > 0) begin
				if (shift >= 32) return 32'd0;
				v = mant << shift;
				return v[31:0];
			end
			if (shift == 0) return mant[31:0];
			down = -shift;
			if (down >= 64) return 32'd0;
			v = mant >> down;
			rem = mant & ((64'd1 << down) - 64'd1);
			half = 64'd1 << (down - 1);
			return v[31:0] + ((rem >= half) ? 32'd1 : 32'd0);
		endfunction

		function void emit(bit kind, bit [31:0] value, logic [2:0] st, bit last);
			asd_pkg::result_t r;
			r.kind = kind;
			r.sample = value;
			r.status = st;
			r.channels = ch;
			r.rate = rate;
			r.bits = bits[5:0];
			r.last = last;
			expected.insert(expected.size(), r);
		endfunction

		function void finish(logic [2:0] st);
			phase = P_DONE;
			emit(1'b1, 32'd0, st, 1'b1);
		endfunction

		function void chunk_end(longint unsigned len);
			longint unsigned nxt;
			nxt = cstart + 8 + clen + clen[0];
			if (nxt + 8 > len) begin
				finish(comm ? asd_pkg::ST_MALFORMED : asd_pkg::ST_MISSING_COMM);
			end else begin
				cstart = nxt;
				phase = clen[0] ? P_PAD : P_CHUNK_HDR;
			end
		endfunction

		// Advance the parser by one accepted byte and queue what it produces.
		function void note_byte(bit [7:0] b);
			longint unsigned len, p, off, boff, chk, cnt, bpb;
			bit [31:0] v, m;
			bit stop;
			len = (flen == 0) ? 64'd1 : flen;
			p = pos;
			off = p - cstart;
			boff = off - 8;
			stop = 0;
			case (phase)
				P_HEADER: begin
					if (p == 0 && len < 12) begin
						finish(asd_pkg::ST_NOT_AIFF);
					end else begin
						ctag = {ctag[23:0], b};
						if (p == 3 && ctag != asd_pkg::TAG_FORM) begin
							finish(asd_pkg::ST_NOT_AIFF);
						end else if (p >= 11) begin
							if (ctag == asd_pkg::TAG_AIFC) aifc = 1;
							if (ctag != asd_pkg::TAG_AIFC && ctag != asd_pkg::TAG_AIFF) begin
								finish(asd_pkg::ST_NOT_AIFF);
							end else begin
								cstart = 12;
								if (len < 20) finish(asd_pkg::ST_MISSING_COMM);
								else phase = P_CHUNK_HDR;
							end
						end
					end
				end
				P_CHUNK_HDR: begin
					if (off < 4) ctag = {ctag[23:0], b};
					else clen = {clen[23:0], b};
					if (off >= 7) begin
						if (cstart + 8 + clen > len) finish(asd_pkg::ST_MALFORMED);
						else if (ctag == asd_pkg::TAG_COMM) begin
							if (clen < 18) finish(asd_pkg::ST_MALFORMED);
							else phase = P_COMM;
						end else if (ctag == asd_pkg::TAG_SSND) begin
							if (!comm) finish(asd_pkg::ST_MISSING_COMM);
							else if (clen < 8) finish(asd_pkg::ST_MALFORMED);
							else phase = P_SSND_HDR;
						end else if (clen == 0) chunk_end(len);
						else phase = P_SKIP;
					end
				end
				P_COMM: begin
					chk = (aifc && clen >= 22) ? 64'd21 : 64'd17;
					if (boff < 2) ch = {ch[7:0], b};
					else if (boff < 6) frames = {frames[23:0], b};
					else if (boff < 8) bits = {bits[7:0], b};
					else if (boff < 10) se = {se[7:0], b};
					else if (boff < 18) mant = {mant[55:0], b};
					else if (boff < 22) ctag = {ctag[23:0], b};
					if (boff == 17) rate = rate_from_extended();
					if (boff == chk) begin
						stop = 1;
						if (chk == 21 && ctag != asd_pkg::TAG_NONE)
							finish(asd_pkg::ST_UNSUPPORTED);
						else if (ch == 0 || rate == 0) finish(asd_pkg::ST_MALFORMED);
						else if (bits != 8 && bits != 16 && bits != 24 && bits != 32)
							finish(asd_pkg::ST_UNSUPPORTED);
						else begin
							comm = 1;
							stop = 0;
						end
					end
					if (!stop && boff + 1 >= clen) chunk_end(len);
				end
				P_SKIP: begin
					if (boff + 1 >= clen) chunk_end(len);
				end
				P_PAD: phase = P_CHUNK_HDR;
				P_SSND_HDR: begin
					if (boff < 4) doff = {doff[23:0], b};
					if (boff >= 7) begin
						cnt = longint'(frames) * longint'(ch);
						bpb = 64'(bits >> 3);
						if (longint'(doff) > longint'(clen) - 8) finish(asd_pkg::ST_MALFORMED);
						else if (cnt * bpb > longint'(clen) - 8 - longint'(doff))
							finish(asd_pkg::ST_MALFORMED);
						else begin
							left = cnt[47:0];
							bis = 0;
							asm_word = 0;
							if (cnt == 0) finish(asd_pkg::ST_OK);
							else phase = (doff != 0) ? P_SSND_OFS : P_SAMPLES;
						end
					end
				end
				P_SSND_OFS: begin
					if (boff + 1 >= 8 + longint'(doff)) phase = P_SAMPLES;
				end
				P_SAMPLES: begin
					bpb = 64'(bits >> 3);
					asm_word = {asm_word[23:0], b};
					if (bpb == 0 || bis + 1 >= bpb) begin
						v = asm_word;
						if (bits >= 1 && bits < 32) begin
							m = 32'd1 << (bits - 1);
							v &= (m << 1) - 32'd1;
							v = (v ^ m) - m;
						end
						emit(1'b0, v, asd_pkg::ST_OK, 1'b0);
						asm_word = 0;
						bis = 0;
						if (left > 0) left--;
						if (left == 0) finish(asd_pkg::ST_OK);
					end else begin
						bis = bis + 2'd1;
					end
				end
				default: ;
			endcase
			pos = p + 1;
			if (pos >= len) clear_file();
		endfunction

		function void report(string field, longint exp_v, longint act_v);
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %0h got %0h at %0t", field, exp_v, act_v, $time);
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_result(asd_pkg::result_t got);
			asd_pkg::result_t e;
			if (expected.size() == 0) begin
				report("unexpected result, kind", -1, got.kind);
				return;
			end
			e = expected.pop_front();
			if (got.kind !== e.kind) report("result_kind", e.kind, got.kind);
			if (got.sample !== e.sample) report("sample_value", e.sample, got.sample);
			if (got.status !== e.status) report("status_code", e.status, got.status);
			if (got.channels !== e.channels) report("channel_count", e.channels, got.channels);
			if (got.rate !== e.rate) report("rate_hz", e.rate, got.rate);
			if (got.bits !== e.bits) report("sample_bits", e.bits, got.bits);
			if (got.last !== e.last) report("last_of_file", e.last, got.last);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic file_length_we = 0;
	logic [31:0] file_length = 32'd1;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] data_byte = 8'd0;
	logic out_valid;
	logic out_stall = 0;
	logic result_kind;
	logic signed [31:0] sample_value;
	logic [2:0] status_code;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [5:0] sample_bits;
	logic last_of_file;

	aiff_stream_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.file_length_we(file_length_we), .file_length(file_length),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .sample_value(sample_value), .status_code(status_code),
		.channel_count(channel_count), .rate_hz(rate_hz), .sample_bits(sample_bits),
		.last_of_file(last_of_file)
	);

	sample_scoreboard_t sb = new();
	bit [7:0] file_bytes[$];
	int bytes_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_req = 0;
	bit long_file = 0;
	int hold_cnt = 0;
	int stall_mode = 0;
	int cycle = 0;

	always #5 clk = ~clk;

	// Receiver: periodically pick one of three stall patterns; a hold-off request
	// overrides it and stalls for a long stretch so the result queue fills.
	always @(negedge clk) begin
		cycle++;
		if (cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall = 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = HOLD_OFF_CYCLES;
			out_stall = 1;
		end else begin
			case (stall_mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 9) < 3);
				default: out_stall = (cycle % 5 < 2);
			endcase
		end
	end

	// Sample results at the rising edge and feed the watchdog.
	always @(posedge clk) begin
		asd_pkg::result_t got;
		if (out_valid && !out_stall) begin
			got.kind = result_kind;
			got.sample = sample_value;
			got.status = status_code;
			got.channels = channel_count;
			got.rate = rate_hz;
			got.bits = sample_bits;
			got.last = last_of_file;
			sb.check_result(got);
		end
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one byte; start a new burst after a random gap when the old one runs out.
	// Called at a falling edge, returns at a falling edge with valid still high.
	task send_byte(input bit [7:0] b);
		if (burst_left == 0) begin
			in_valid = 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_valid = 1;
		data_byte = b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Hold input until every predicted result has come, then allow the pipeline to drain.
	task wait_idle();
		in_valid = 0;
		while (sb.expected.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_length(input bit [31:0] v);
		in_valid = 0;
		file_length_we = 1;
		file_length = v;
		@(posedge clk);
		sb.flen = v;
		@(negedge clk);
		file_length_we = 0;
	endtask

	task add_byte(input bit [7:0] b);
		file_bytes.insert(file_bytes.size(), b);
	endtask

	task push32(input bit [31:0] w);
		for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
	endtask

	task push_random(input int n);
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endtask

	// Build one file in file_bytes, shaped by mode.
	task build_file(input int mode);
		bit is_c;
		bit [15:0] nch, nbits, exp_se;
		bit [31:0] nframes, r, clen, doff;
		bit [63:0] m64;
		int msb, nbytes;
		file_bytes.delete();
		is_c = (mode == M_AIFC || mode == M_AIFC_COMPRESSED) ? 1 : $urandom_range(0, 1);
		push32(mode == M_NO_FORM ? $urandom() : asd_pkg::TAG_FORM);
		push32($urandom());
		push32(mode == M_BAD_FORM_TYPE ? asd_pkg::TAG_COMM :
			(is_c ? asd_pkg::TAG_AIFC : asd_pkg::TAG_AIFF));
		if (mode == M_GARBAGE) begin
			push_random($urandom_range(0, 40));
			return;
		end
		if (mode == M_JUNK_CHUNK || $urandom_range(0, 2) == 0) begin
			clen = $urandom_range(0, 5);
			push32(TAG_JUNK);
			push32(clen);
			push_random(clen + clen[0]);
		end
		if (mode == M_SSND_FIRST) begin
			push32(asd_pkg::TAG_SSND);
			push32(32'd8);
			push_random(8);
		end
		nframes = $urandom_range(0, 4);
		nch = (mode == M_NO_CHANNELS) ? 16'd0 : 16'($urandom_range(1, 3));
		if ($urandom_range(0, 15) == 0) begin
			nch = 16'hFFFF;
			nframes = 0;
		end
		// Many samples, so the result queue fills while the receiver holds off.
		if (long_file) begin
			nch = 16'd2;
			nframes = 32'd40;
		end
		if (mode == M_NO_FRAMES) nframes = 0;
		case ($urandom_range(0, 3))
			0: nbits = 8;
			1: nbits = 16;
			2: nbits = 24;
			default: nbits = 32;
		endcase
		if (mode == M_BAD_BITS) nbits = 16'($urandom_range(0, 40));
		if (mode == M_SHORT_COMM) clen = $urandom_range(0, 17);
		else if (is_c) clen = 22 + $urandom_range(0, 1);
		else clen = 18 + ($urandom_range(0, 3) == 0);
		// Sample rate as an 80-bit extended value.
		if (mode == M_FLAT_RATE) begin
			exp_se = 16'(16383 + 63);
			m64 = {1'b1, 31'($urandom()), 32'($urandom())};
		end else if (!long_file && $urandom_range(0, 7) == 0) begin
			exp_se = 16'($urandom());
			m64 = {32'($urandom()), 32'($urandom())};
		end else begin
			r = ($urandom_range(0, 15) == 0) ? 32'hFFFFFFFF : $urandom_range(1, 200000);
			msb = 0;
			for (int i = 0; i < 32; i++) if (r[i]) msb = i;
			exp_se = 16'(16383 + msb);
			m64 = 64'(r) << (63 - msb);
		end
		push32(asd_pkg::TAG_COMM);
		push32(clen);
		if (mode == M_SHORT_COMM) begin
			push_random(clen + clen[0]);
		end else begin
			add_byte(nch[15:8]);
			add_byte(nch[7:0]);
			push32(nframes);
			add_byte(nbits[15:8]);
			add_byte(nbits[7:0]);
			add_byte(exp_se[15:8]);
			add_byte(exp_se[7:0]);
			push32(m64[63:32]);
			push32(m64[31:0]);
			if (clen >= 22) begin
				push32(mode == M_AIFC_COMPRESSED ? TAG_JUNK : asd_pkg::TAG_NONE);
				push_random(clen - 22);
			end else begin
				push_random(clen - 18);
			end
			if (clen[0]) push_random(1);
		end
		doff = (mode == M_BAD_OFFSET) ? 32'd100 : $urandom_range(0, 3);
		nbytes = nframes * nch * (nbits >> 3);
		if (mode == M_BAD_OFFSET) nbytes = 0;
		clen = 8 + ((mode == M_BAD_OFFSET) ? 0 : doff) + nbytes + $urandom_range(0, 2);
		push32(asd_pkg::TAG_SSND);
		push32(clen);
		push32(doff);
		push32($urandom());
		push_random(clen - 8 + clen[0]);
		push_random($urandom_range(0, 3));
	endtask

	// Send a file; the length register usually matches it, sometimes cuts it
	// short or runs past it into trailing noise.
	task send_file(input int mode, input bit exact);
		int n;
		int sel;
		build_file(mode);
		n = file_bytes.size();
		sel = exact ? 9 : $urandom_range(0, 9);
		if (sel == 0) n = $urandom_range(1, file_bytes.size());
		else if (sel == 1) n = file_bytes.size() + $urandom_range(1, 6);
		wait_idle();
		write_length(n);
		if (long_file) hold_req = 1;
		for (int i = 0; i < n; i++)
			send_byte(i < file_bytes.size() ? file_bytes[i] : 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int mode;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Zero length acts as one byte per file.
		write_length(32'd0);
		send_byte(8'hFF);
		send_byte(8'h00);
		// A length below the header size is rejected on the first byte.
		wait_idle();
		write_length(32'd5);
		repeat (5) send_byte(8'($urandom_range(0, 255)));
		// Full-scale length: reject the header, then shorten the length so the
		// file closes out.
		wait_idle();
		write_length(32'hFFFFFFFF);
		repeat (4) send_byte(8'h00);
		wait_idle();
		write_length(32'd10);
		repeat (6) send_byte(8'h46);
		// One file down each path: every status code and the special cases.
		for (int i = 0; i < M_COUNT; i++) send_file(i, 1);

		// Hold off the receiver while a long well-formed file streams in.
		long_file = 1;
		send_file(M_AIFF, 1);
		long_file = 0;

		// Random part: mostly well-formed files with random content.
		while (bytes_sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0, 1, 2: mode = M_AIFF;
				3, 4: mode = M_AIFC;
				5: mode = M_JUNK_CHUNK;
				default: mode = $urandom_range(0, M_COUNT - 1);
			endcase
			send_file(mode, 0);
		end

		wait_idle();
		repeat (4) @(negedge clk);
		sb.errors += sb.expected.size();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/asd_pkg.sv
src/asd_parser.sv
src/asd_out_fifo.sv
src/aiff_stream_decoder_top.sv
verif/aiff_stream_decoder_top_test.sv
